>>> hw/rtl/lecm_pkg.sv
// Shared types and constants for the line editor / command matcher.
// Holds byte codes, the command name table and the result status codes.
// No dependencies.
package lecm_pkg;

    // Default line buffer size (characters held is at most LINE_SIZE-1)
    localparam int LINE_SIZE_DEF = 64;

    // Only the first HOLD_DEPTH characters can decide a match
    localparam int HOLD_DEPTH = 7;
    localparam int HOLD_IDX_W = $clog2(HOLD_DEPTH);
    localparam int NAME_COUNT = 17;
    localparam int INDEX_W    = 5;
    localparam int CHARS_W    = 6;
    localparam int NAME_LEN_W = 3;

    typedef logic [7:0] char_t;

    // Byte codes
    localparam char_t CODE_LF       = 8'd10;
    localparam char_t CODE_CR       = 8'd13;
    localparam char_t CODE_BS       = 8'd8;
    localparam char_t CODE_DEL      = 8'd127;
    localparam char_t CODE_PRINT_LO = 8'h20;
    localparam char_t CODE_PRINT_HI = 8'h7e;

    // Result status codes
    typedef enum logic [1:0] {
        ST_MATCH    = 2'd0,
        ST_UNKNOWN  = 2'd1,
        ST_TOO_LONG = 2'd2
    } line_status_t;

    // Match result handed from the name matcher to the top level
    typedef struct packed {
        logic               hit;
        logic [INDEX_W-1:0] index;
    } match_t;

    // Command names, left aligned, zero padded to HOLD_DEPTH characters
    localparam logic [8*HOLD_DEPTH-1:0] NAME_TEXT [NAME_COUNT] = '{
        {"help",    24'h0},
        {"build",   16'h0},
        {"threads"},
        {"runq",    24'h0},
        {"current"},
        {"waits",   16'h0},
        {"mem",     32'h0},
        {"pages",   16'h0},
        {"maps",    24'h0},
        {"handles"},
        {"ports",   16'h0},
        {"irqs",    24'h0},
        {"perf",    24'h0},
        {"trace",   16'h0},
        {"mmu",     32'h0},
        {"faults",  8'h0},
        {"devices"}
    };

    localparam logic [NAME_LEN_W-1:0] NAME_LEN [NAME_COUNT] = '{
        3'd4, 3'd5, 3'd7, 3'd4, 3'd7, 3'd5, 3'd3, 3'd5, 3'd4,
        3'd7, 3'd5, 3'd4, 3'd4, 3'd5, 3'd3, 3'd6, 3'd7
    };

endpackage

>>> hw/rtl/line_editor_command_matcher_top.sv
// Top level of the line editor / command matcher: input register, line
// state, name matcher and result register. Depends on lecm_pkg and
// lecm_name_match.
//
//  channel | signals                                     | direction
//  --------+---------------------------------------------+----------
//  input   | in_valid, in_stall, rx_byte[7:0]            | in
//  result  | out_valid, out_stall, line_status[1:0],     | out
//          | cmd_index[4:0], line_chars[5:0]             |
//
// One byte per cycle sustained while the result channel is not stalled; the
// result of a line end passes from the input register through one pass of edit
// and match into the result register.
// Reset clears the line count, overflow flag and both valid flags; the
// held characters are not cleared.
// A stalled result holds the edit stage; while the input register holds a
// byte that cannot advance, the input is stalled in that same cycle.
module line_editor_command_matcher_top #(
    parameter int LINE_SIZE = lecm_pkg::LINE_SIZE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  lecm_pkg::char_t                 rx_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output lecm_pkg::line_status_t          line_status,
    output logic [lecm_pkg::INDEX_W-1:0]    cmd_index,
    output logic [lecm_pkg::CHARS_W-1:0]    line_chars
);
    import lecm_pkg::*;

    localparam int CNT_W = $clog2(LINE_SIZE);
    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(LINE_SIZE - 1);

    logic                  in_valid_reg;
    char_t                 in_byte_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    char_t                 chars_reg [HOLD_DEPTH];
    logic                  out_valid_reg;
    line_status_t          status_reg, status_next;
    logic [INDEX_W-1:0]    index_reg, index_next;
    logic [CHARS_W-1:0]    chars_cnt_reg;
    logic                  advance;
    logic                  take_in;
    logic                  emit;
    logic                  wr_en;
    logic                  is_eol, is_erase, is_print;
    match_t                match;

    // Edit stage moves when its byte can land in the result register
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take_in)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Capture the byte of an accepted transaction
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // Compare the current line against the name table
    lecm_name_match #(
        .CNT_W (CNT_W)
    ) u_match (
        .chars (chars_reg),
        .count (count_reg),
        .match (match)
    );

    // Classify the byte
    assign is_eol   = (in_byte_reg == CODE_CR) || (in_byte_reg == CODE_LF);
    assign is_erase = (in_byte_reg == CODE_BS) || (in_byte_reg == CODE_DEL);
    assign is_print = (in_byte_reg >= CODE_PRINT_LO) && (in_byte_reg <= CODE_PRINT_HI);

    // Edit the line and build the result
    always_comb
    begin
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        wr_en       = 1'b0;
        emit        = 1'b0;
        status_next = ST_UNKNOWN;
        index_next  = '0;
        if (advance)
        begin
            if (is_eol)
            begin
                if (ovf_reg)
                begin
                    emit        = 1'b1;
                    status_next = ST_TOO_LONG;
                end
                else if (count_reg != '0)
                begin
                    emit        = 1'b1;
                    status_next = match.hit ? ST_MATCH : ST_UNKNOWN;
                    index_next  = match.hit ? match.index : '0;
                end
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else if (is_erase)
            begin
                if (!ovf_reg && count_reg != '0)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            else if (is_print && !ovf_reg)
            begin
                if (count_reg >= COUNT_MAX)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    wr_en      = (count_reg < CNT_W'(HOLD_DEPTH));
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    // Line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Hold the leading characters of the line
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            chars_reg[count_reg[HOLD_IDX_W-1:0]] <= in_byte_reg;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            status_reg    <= status_next;
            index_reg     <= index_next;
            chars_cnt_reg <= CHARS_W'(count_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign line_status = status_reg;
    assign cmd_index   = index_reg;
    assign line_chars  = chars_cnt_reg;

    // Count never passes the line limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("line count beyond limit");

    // Overflow only ever sits at a full line
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> count_reg == COUNT_MAX)
        else $error("overflow flag without full line");

    // A line end clears the line
    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_eol |=> count_reg == '0 && !ovf_reg)
        else $error("line not cleared after line end");

    // Too-long and unknown results carry index zero
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_MATCH |-> index_reg == '0)
        else $error("nonzero index on unmatched result");

    // Input is held off only while the result register is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall && in_valid_reg)
        else $error("input stalled without a blocked result");

endmodule

>>> hw/rtl/lecm_name_match.sv
// Parallel compare of the held line against the fixed command name table.
// Depends on lecm_pkg (name table, match_t).
module lecm_name_match #(
    parameter int CNT_W = 6
) (
    input  lecm_pkg::char_t  chars [lecm_pkg::HOLD_DEPTH],
    input  logic [CNT_W-1:0] count,
    output lecm_pkg::match_t match
);
    import lecm_pkg::*;

    logic [NAME_COUNT-1:0] name_eq;

    // Compare length and the leading characters of every name
    always_comb
    begin
        for (int k = 0; k < NAME_COUNT; k++)
        begin
            name_eq[k] = (count == CNT_W'(NAME_LEN[k]));
            for (int i = 0; i < HOLD_DEPTH; i++)
            begin
                if (i < int'(NAME_LEN[k]) &&
                    chars[i] != NAME_TEXT[k][8*(HOLD_DEPTH-i)-1 -: 8])
                begin
                    name_eq[k] = 1'b0;
                end
            end
        end
    end

    // Pick the lowest matching index
    always_comb
    begin
        match.hit   = 1'b0;
        match.index = '0;
        for (int k = NAME_COUNT-1; k >= 0; k--)
        begin
            if (name_eq[k])
            begin
                match.hit   = 1'b1;
                match.index = INDEX_W'(k);
            end
        end
    end

endmodule

>>> tb/line_editor_command_matcher_checker.sv
`timescale 1ns / 100ps
// Checker for the line editor / command matcher: tracks the line being edited,
// predicts each line result and compares it with the result channel.
// Depends on lecm_pkg for port types and byte codes.
module line_editor_command_matcher_checker #(
    parameter int LINE_SIZE = lecm_pkg::LINE_SIZE_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  lecm_pkg::char_t         rx_byte,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  lecm_pkg::line_status_t  line_status,
    input  logic [4:0]              cmd_index,
    input  logic [5:0]              line_chars,
    output int                      pending,
    output int                      mismatches
);
    import lecm_pkg::*;

    localparam int HELD_CHARS = 7;
    localparam int CMD_COUNT  = 17;
    localparam int PRINT_MAX  = 100;

    typedef struct {
        line_status_t status;
        logic [4:0]   index;
        logic [5:0]   chars;
    } line_result_t;

    // Line state as the block should hold it
    char_t        held [HELD_CHARS];
    int unsigned  line_len;
    bit           over;
    line_result_t expected_lines [$];

    // Command table, kept apart from the one in the package
    function automatic string command_name(input int k);
        case (k)
            0:       return "help";
            1:       return "build";
            2:       return "threads";
            3:       return "runq";
            4:       return "current";
            5:       return "waits";
            6:       return "mem";
            7:       return "pages";
            8:       return "maps";
            9:       return "handles";
            10:      return "ports";
            11:      return "irqs";
            12:      return "perf";
            13:      return "trace";
            14:      return "mmu";
            15:      return "faults";
            default: return "devices";
        endcase
    endfunction

    function automatic bit line_is(input int k);
        string nm;
        int    i;
        nm = command_name(k);
        if (nm.len() != line_len)
            return 1'b0;
        for (i = 0; i < nm.len(); i++)
            if (held[i] != nm[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_MAX)
            $display("ERROR at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Apply one accepted byte to the line and queue the result it ends with
    task automatic edit_line(input char_t b);
        line_result_t r;
        int           k;
        if (b == CODE_CR || b == CODE_LF)
        begin
            if (over || line_len != 0)
            begin
                r.chars  = line_len[5:0];
                r.index  = '0;
                r.status = over ? ST_TOO_LONG : ST_UNKNOWN;
                for (k = 0; k < CMD_COUNT; k++)
                begin
                    if (!over && r.status == ST_UNKNOWN && line_is(k))
                    begin
                        r.status = ST_MATCH;
                        r.index  = k[4:0];
                    end
                end
                expected_lines.push_back(r);
            end
            line_len = 0;
            over     = 1'b0;
        end
        else if (b == CODE_BS || b == CODE_DEL)
        begin
            if (!over && line_len != 0)
                line_len--;
        end
        else if (b >= CODE_PRINT_LO && b <= CODE_PRINT_HI && !over)
        begin
            if (line_len >= LINE_SIZE - 1)
                over = 1'b1;
            else
            begin
                if (line_len < HELD_CHARS)
                    held[line_len] = b;
                line_len++;
            end
        end
    endtask

    // Check results first, then take in the byte of this edge
    always @(posedge clk or negedge rst_n)
    begin
        line_result_t want;
        if (!rst_n)
        begin
            line_len = 0;
            over     = 1'b0;
            expected_lines.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_lines.size() == 0)
                    report_mismatch($sformatf(
                        "result with none expected: status=%0d index=%0d chars=%0d",
                        line_status, cmd_index, line_chars));
                else
                begin
                    want = expected_lines.pop_front();
                    if (line_status !== want.status)
                        report_mismatch($sformatf("line_status %0d, expected %0d",
                            line_status, want.status));
                    if (cmd_index !== want.index)
                        report_mismatch($sformatf("cmd_index %0d, expected %0d",
                            cmd_index, want.index));
                    if (line_chars !== want.chars)
                        report_mismatch($sformatf("line_chars %0d, expected %0d",
                            line_chars, want.chars));
                end
            end
            if (in_valid && !in_stall)
                edit_line(rx_byte);
            pending <= expected_lines.size();
        end
    end

endmodule

>>> tb/line_editor_command_matcher_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the line editor / command matcher: drives byte streams of
// command lines under varying idle and stall rates and gives the verdict.
// Depends on lecm_pkg, the block and line_editor_command_matcher_checker.
module line_editor_command_matcher_top_tb;
    import lecm_pkg::*;

    localparam int LINE_SIZE      = LINE_SIZE_DEF;
    localparam int PHASE_ITEMS    = 188;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         in_valid = 1'b0;
    logic         in_stall;
    char_t        rx_byte = '0;
    logic         out_valid;
    logic         out_stall = 1'b0;
    line_status_t line_status;
    logic [4:0]   cmd_index;
    logic [5:0]   line_chars;

    int pending;
    int mismatches;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    line_editor_command_matcher_top #(
        .LINE_SIZE     (LINE_SIZE)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .line_status   (line_status),
        .cmd_index     (cmd_index),
        .line_chars    (line_chars)
    );

    line_editor_command_matcher_checker #(
        .LINE_SIZE     (LINE_SIZE)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .line_status   (line_status),
        .cmd_index     (cmd_index),
        .line_chars    (line_chars),
        .pending       (pending),
        .mismatches    (mismatches)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Stall the result channel at the rate of the current phase
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Abort when no transaction moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic char_t any_printable();
        return char_t'($urandom_range(CODE_PRINT_HI, CODE_PRINT_LO));
    endfunction

    function automatic char_t any_erase();
        return $urandom_range(1) ? CODE_BS : CODE_DEL;
    endfunction

    // Character i of command k; names are left aligned in the table
    function automatic char_t name_char(input int k, input int i);
        return NAME_TEXT[k][8*(HOLD_DEPTH-i)-1 -: 8];
    endfunction

    // Offer one byte after an optional idle gap, hold it until accepted
    task automatic send_byte(input char_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (b == CODE_CR || b == CODE_LF || b == CODE_BS || b == CODE_DEL ||
            (b >= CODE_PRINT_LO && b <= CODE_PRINT_HI))
            items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // One line of a random kind, mostly well formed commands
    task automatic send_random_line();
        int kind, k, len, i, mode, pos;
        bit ends;
        kind = $urandom_range(99);
        k    = $urandom_range(NAME_COUNT - 1);
        len  = NAME_LEN[k];
        ends = 1'b1;
        if (kind < 45)
        begin
            // command name, now and then with a typo that gets erased
            for (i = 0; i < len; i++)
            begin
                if ($urandom_range(7) == 0)
                begin
                    send_byte(any_printable());
                    send_byte(any_erase());
                end
                send_byte(name_char(k, i));
            end
        end
        else if (kind < 60)
        begin
            // near miss: drop the last char, add one, or replace one
            mode = $urandom_range(2);
            pos  = $urandom_range(len - 1);
            for (i = 0; i < len; i++)
                if (!(mode == 0 && i == len - 1))
                    send_byte((mode == 2 && i == pos) ? any_printable() : name_char(k, i));
            if (mode == 1)
                send_byte(any_printable());
        end
        else if (kind < 78)
        begin
            // random text with erases, which may run past the start of the line
            len = $urandom_range(10, 1);
            for (i = 0; i < len; i++)
                send_byte(($urandom_range(4) == 0) ? any_erase() : any_printable());
        end
        else if (kind < 82)
        begin
            // line around the buffer size, then erase or type past the end
            len = $urandom_range(LINE_SIZE + 3, LINE_SIZE - 3);
            for (i = 0; i < len; i++)
                send_byte(any_printable());
            repeat ($urandom_range(3))
                send_byte($urandom_range(1) ? any_erase() : any_printable());
        end
        else if (kind < 92)
        begin
            // raw noise over the whole byte range
            ends = 1'b0;
            repeat ($urandom_range(4, 1))
                send_byte(char_t'($urandom_range(255)));
        end
        else if ($urandom_range(1))
            send_byte(any_erase());
        if (ends)
            send_byte($urandom_range(1) ? CODE_CR : CODE_LF);
    endtask

    initial
    begin
        int ph, phase_start;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: erase on an empty line, empty line, ignored bytes,
        // a match, an unknown line, a match after erasing a stray char
        send_byte(CODE_BS);
        send_byte(CODE_DEL);
        send_byte(CODE_LF);
        send_byte(8'h00);
        send_byte(8'hff);
        send_text("mem");
        send_byte(CODE_CR);
        send_text(" ~");
        send_byte(CODE_LF);
        send_text("devicesX");
        send_byte(CODE_DEL);
        send_byte(CODE_LF);

        // Random lines in phases of idle and stall pressure
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 55;
                end
                default:
                begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 14;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_line();
            // hold the sender until every result is back
            in_valid <= 1'b0;
            while (pending != 0)
                @(posedge clk);
            @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
